>>> rtl/uvsig_pkg.sv
// Package of shared types and constants for the UV sphere index generator.
package uvsig_pkg;

  // Configured resolution and vertex index widths, resolution limits and reset value.
  localparam int unsigned ResCfgW    = 9;
  localparam int unsigned VtxW       = 16;
  localparam int unsigned MaxResDflt = 256;
  localparam int unsigned MinRes     = 3;
  localparam logic [ResCfgW-1:0] ResReset = ResCfgW'(16);

  // Sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PhFan   = 4'b0001,
    PhClose = 4'b0010,
    PhBody  = 4'b0100,
    PhDone  = 4'b1000
  } phase_e;

  // One emitted triangle.
  typedef struct packed {
    logic [VtxW-1:0] corner_a;
    logic [VtxW-1:0] corner_b;
    logic [VtxW-1:0] corner_c;
    logic            last_triangle;
  } tri_t;

endpackage

>>> rtl/uvsig_tri_gen.sv
// Triangle sequencer: walks the sphere layout and forms one triangle per transaction.
module uvsig_tri_gen #(
  parameter int unsigned MaxRes = uvsig_pkg::MaxResDflt
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uvsig_pkg::ResCfgW-1:0]  cfg_wdata_i,
  input  logic                           step_i,
  input  logic                           restart_i,
  output logic                           push_o,
  output uvsig_pkg::tri_t                tri_o
);

  localparam int unsigned ResW = $clog2(MaxRes + 1);
  localparam int unsigned VtxW = uvsig_pkg::VtxW;

  logic [uvsig_pkg::ResCfgW-1:0] resolution_q;
  uvsig_pkg::phase_e             phase_q, phase_d;
  logic [ResW-1:0]               step_q, step_d;
  logic [ResW-1:0]               ring_q, ring_d;
  logic                          half_q, half_d;
  logic [VtxW-1:0]               base_q, base_d;
  logic [VtxW-1:0]               last_q, last_d;
  logic [ResW-1:0]               res_q, res_d;

  logic [ResW-1:0]     clamp_res;
  logic [2*ResW-1:0]   clamp_prod;
  logic [VtxW-1:0]     r16, i16, lu, ld, ru, rd;
  logic                step_end, ring_end;
  uvsig_pkg::phase_e   w_phase;
  logic [ResW-1:0]     w_step, w_ring;
  logic                w_half;
  logic [VtxW-1:0]     w_base, w_last;
  logic [ResW-1:0]     w_res;

  // Resolution clamped into the supported range.
  always_comb begin
    if (resolution_q < uvsig_pkg::ResCfgW'(uvsig_pkg::MinRes)) begin
      clamp_res = ResW'(uvsig_pkg::MinRes);
    end else if (resolution_q > uvsig_pkg::ResCfgW'(MaxRes)) begin
      clamp_res = ResW'(MaxRes);
    end else begin
      clamp_res = ResW'(resolution_q);
    end
  end

  assign clamp_prod = {{ResW{1'b0}}, clamp_res - ResW'(2)} * {{ResW{1'b0}}, clamp_res};

  // Working state: a restart reloads everything before the triangle is formed.
  always_comb begin
    if (restart_i) begin
      w_phase = uvsig_pkg::PhFan;
      w_step  = ResW'(1);
      w_ring  = '0;
      w_half  = 1'b0;
      w_base  = '0;
      w_res   = clamp_res;
      w_last  = VtxW'(clamp_prod) + VtxW'(1);
    end else begin
      w_phase = phase_q;
      w_step  = step_q;
      w_ring  = ring_q;
      w_half  = half_q;
      w_base  = base_q;
      w_res   = res_q;
      w_last  = last_q;
    end
  end

  assign r16      = VtxW'(w_res);
  assign i16      = VtxW'(w_step);
  assign step_end = ({1'b0, w_step} + (ResW+1)'(1)) >= {1'b0, w_res};
  assign ring_end = ({1'b0, w_ring} + (ResW+1)'(4)) >= {1'b0, w_res};

  // Quad corners of the ring pair; the seam quad wraps back to the ring start.
  always_comb begin
    if (step_end) begin
      lu = w_base + r16;
      ld = w_base + (r16 << 1);
      ru = w_base + VtxW'(1);
      rd = w_base + r16 + VtxW'(1);
    end else begin
      lu = w_base + i16 + VtxW'(1);
      ld = w_base + r16 + i16 + VtxW'(1);
      ru = w_base + i16 + VtxW'(2);
      rd = w_base + r16 + i16 + VtxW'(2);
    end
  end

  always_comb begin
    phase_d = w_phase;
    step_d  = w_step;
    ring_d  = w_ring;
    half_d  = ~w_half;
    base_d  = w_base;
    last_d  = w_last;
    res_d   = w_res;
    tri_o   = '0;
    push_o  = step_i;
    case (w_phase)
      uvsig_pkg::PhFan: begin
        if (!w_half) begin
          tri_o.corner_a = '0;
          tri_o.corner_b = i16;
          tri_o.corner_c = i16 + VtxW'(1);
        end else begin
          tri_o.corner_a = w_last;
          tri_o.corner_b = w_last - i16;
          tri_o.corner_c = w_last - i16 - VtxW'(1);
          if (step_end) begin
            phase_d = uvsig_pkg::PhClose;
          end else begin
            step_d = w_step + ResW'(1);
          end
        end
      end
      uvsig_pkg::PhClose: begin
        if (!w_half) begin
          tri_o.corner_a = '0;
          tri_o.corner_b = VtxW'(1);
          tri_o.corner_c = r16;
        end else begin
          tri_o.corner_a = w_last;
          tri_o.corner_b = w_last - VtxW'(1);
          tri_o.corner_c = w_last - r16;
          if (w_res == ResW'(uvsig_pkg::MinRes)) begin
            tri_o.last_triangle = 1'b1;
            phase_d             = uvsig_pkg::PhDone;
          end else begin
            phase_d = uvsig_pkg::PhBody;
            step_d  = '0;
            ring_d  = '0;
            base_d  = '0;
          end
        end
      end
      uvsig_pkg::PhBody: begin
        if (!w_half) begin
          tri_o.corner_a = lu;
          tri_o.corner_b = ld;
          tri_o.corner_c = ru;
        end else begin
          tri_o.corner_a = ld;
          tri_o.corner_b = ru;
          tri_o.corner_c = rd;
          if (step_end) begin
            if (ring_end) begin
              tri_o.last_triangle = 1'b1;
              phase_d             = uvsig_pkg::PhDone;
            end
            step_d = '0;
            ring_d = w_ring + ResW'(1);
            base_d = w_base + r16;
          end else begin
            step_d = w_step + ResW'(1);
          end
        end
      end
      default: begin
        // Finished or never started: nothing to emit, state stays.
        push_o = 1'b0;
        half_d = w_half;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resolution_q <= uvsig_pkg::ResReset;
    end else if (cfg_we_i) begin
      resolution_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uvsig_pkg::PhDone;
      step_q  <= '0;
      ring_q  <= '0;
      half_q  <= 1'b0;
      base_q  <= '0;
      last_q  <= '0;
      res_q   <= ResW'(uvsig_pkg::MinRes);
    end else if (step_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      ring_q  <= ring_d;
      half_q  <= half_d;
      base_q  <= base_d;
      last_q  <= last_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> rtl/uvsig_out_queue.sv
// Two-entry result queue that separates the output stall from the input side.
module uvsig_out_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  uvsig_pkg::tri_t tri_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output uvsig_pkg::tri_t tri_o
);

  uvsig_pkg::tri_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign tri_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tri_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/uv_sphere_index_generator.sv
// Top level of the UV sphere triangle index generator.
//
// This block emits the vertex indices of a latitude-longitude sphere, one
// triangle per accepted input transaction, and sustains one triangle per
// clock cycle while the output is not stalled. A transaction with restart
// set latches the configured resolution R (clamped to the range 3 to
// MAX_RESOLUTION) and yields the first triangle in the same transaction;
// later transactions with restart clear each yield the next triangle, and
// the final one carries last_triangle. A full sphere is 2*R*(R-2) triangles.
// Transactions after the final triangle, or before the first restart,
// produce no result. The sequencer forms each triangle in the cycle of
// acceptance from its counters and an incremental ring base, and
// registers it in a two-entry result queue that feeds the output. The input
// stalls only when both queue entries are held by a stalled output, which
// keeps the input stall free of any combinational path from the output stall.
// A resolution write takes effect at the next restart and may only be issued
// while the block is idle.
module uv_sphere_index_generator #(
  parameter int unsigned MAX_RESOLUTION = uvsig_pkg::MaxResDflt
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: the resolution register.
  input  logic                           cfg_we_i,
  input  logic [uvsig_pkg::ResCfgW-1:0]  cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [uvsig_pkg::VtxW-1:0]     corner_a_o,
  output logic [uvsig_pkg::VtxW-1:0]     corner_b_o,
  output logic [uvsig_pkg::VtxW-1:0]     corner_c_o,
  output logic                           last_triangle_o
);

  logic            full;
  logic            in_accept;
  logic            push;
  uvsig_pkg::tri_t gen_tri;
  uvsig_pkg::tri_t out_tri;

  // The queue has room whenever it is not full, so the stall never waits on
  // the downstream side in the same cycle.
  assign in_stall_o = full;
  assign in_accept  = in_valid_i && !full;

  uvsig_tri_gen #(
    .MaxRes (MAX_RESOLUTION)
  ) u_tri_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (in_accept),
    .restart_i   (restart_i),
    .push_o      (push),
    .tri_o       (gen_tri)
  );

  uvsig_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .tri_i       (gen_tri),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tri_o       (out_tri)
  );

  assign corner_a_o      = out_tri.corner_a;
  assign corner_b_o      = out_tri.corner_b;
  assign corner_c_o      = out_tri.corner_c;
  assign last_triangle_o = out_tri.last_triangle;

endmodule
